// File: sv/dqs_pkg.sv
package dqs_pkg;

    // Request codes carried on req_type.
    typedef enum logic [3:0] {
        REQ_PUSH_BACK  = 4'd0,
        REQ_PUSH_FRONT = 4'd1,
        REQ_POP_BACK   = 4'd2,
        REQ_POP_FRONT  = 4'd3,
        REQ_READ       = 4'd4,
        REQ_FILL       = 4'd5,
        REQ_ERASE      = 4'd6,
        REQ_CLEAR      = 4'd7,
        REQ_RESIZE     = 4'd8
    } req_code_t;

    // Status codes returned with every result beat.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_BADPOS = 2'd3;

    // Broadcast controls from the sequencer to every cell of the row.
    typedef struct packed {
        logic shift_in;   // open a gap at pos: cells above pos take their left neighbor
        logic shift_out;  // close a gap at pos: cells at and above pos take their right neighbor
        logic load_tap;   // cell at pos copies its word into its tap, others clear
        logic tap_shift;  // taps move one cell toward the front
    } cell_ctrl_t;

endpackage

// File: sv/dqs_cell.sv
module dqs_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int PW         = 9,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  dqs_pkg::cell_ctrl_t   ctrl,
    input  logic [PW-1:0]         pos,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] right_tap,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] tap_reg;
    logic                  is_at;
    logic                  is_after;

    assign is_at    = (pos == MY_IDX);
    assign is_after = (pos < MY_IDX);

    // Element word: no reset, entries above the occupancy hold don't-care data.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_in)
        begin
            if (is_after)
            begin
                data_reg <= left_data;
            end
            else if (is_at)
            begin
                data_reg <= value;
            end
        end
        else if (ctrl.shift_out)
        begin
            if (is_at || is_after)
            begin
                data_reg <= right_data;
            end
        end
    end

    // Read tap: load the selected word, then walk it toward cell zero.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_tap)
        begin
            tap_reg <= is_at ? data_reg : '0;
        end
        else if (ctrl.tap_shift)
        begin
            tap_reg <= right_tap;
        end
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

// File: sv/dqs_ctrl.sv
module dqs_ctrl #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [3:0]            req_type,
    input  logic [CW-1:0]         place,
    input  logic [CW-1:0]         place_end,
    input  logic [CW-1:0]         amount,
    input  logic [DATA_WIDTH-1:0] item_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] read_word,
    output logic [CW-1:0]         occupancy,
    output logic [1:0]            status,
    input  logic [DATA_WIDTH-1:0] tap_head,
    output dqs_pkg::cell_ctrl_t   cell_ctrl,
    output logic [CW-1:0]         cell_pos,
    output logic [DATA_WIDTH-1:0] cell_value
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_INS     = 6'b000010,
        S_DEL     = 6'b000100,
        S_RDLOAD  = 6'b001000,
        S_RDSHIFT = 6'b010000,
        S_FIN     = 6'b100000
    } state_t;

    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_CX = (CW+1)'(DEPTH);

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         steps_reg, steps_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [1:0]            stat_reg, stat_next;
    logic                  rd_reg, rd_next;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [CW-1:0]         occ_reg;
    logic [1:0]            ostat_reg;
    logic                  ovalid_reg;

    logic                  accept;
    logic                  steps_zero;
    logic                  out_free;
    logic                  fin_load;
    logic                  is_full;
    logic                  is_empty;
    logic                  fill_over;
    logic [CW-1:0]         er_start;
    logic [CW-1:0]         er_end;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign in_stall   = (state_reg != S_IDLE);
    assign steps_zero = (steps_reg == '0);
    assign out_free   = !ovalid_reg || !out_stall;
    assign fin_load   = (state_reg == S_FIN) && out_free;

    assign is_full   = (count_reg == DEPTH_C);
    assign is_empty  = (count_reg == '0);
    assign fill_over = (({1'b0, count_reg} + {1'b0, amount}) > DEPTH_CX);
    assign er_start  = (place < count_reg) ? place : count_reg;
    assign er_end    = (place_end < count_reg) ? place_end : count_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        steps_next = steps_reg;
        value_next = value_reg;
        stat_next  = stat_reg;
        rd_next    = rd_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_FIN;
                    pos_next   = place;
                    steps_next = '0;
                    value_next = item_value;
                    stat_next  = dqs_pkg::STAT_OK;
                    rd_next    = 1'b0;
                    case (req_type)
                        dqs_pkg::REQ_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                stat_next = dqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                state_next = S_INS;
                                pos_next   = count_reg;
                                steps_next = CW'(1);
                            end
                        end
                        dqs_pkg::REQ_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                stat_next = dqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                state_next = S_INS;
                                pos_next   = '0;
                                steps_next = CW'(1);
                            end
                        end
                        dqs_pkg::REQ_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                stat_next = dqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DEL;
                                pos_next   = count_reg - CW'(1);
                                steps_next = CW'(1);
                            end
                        end
                        dqs_pkg::REQ_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                stat_next = dqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DEL;
                                pos_next   = '0;
                                steps_next = CW'(1);
                            end
                        end
                        dqs_pkg::REQ_READ:
                        begin
                            if (place >= count_reg)
                            begin
                                stat_next = dqs_pkg::STAT_BADPOS;
                            end
                            else
                            begin
                                state_next = S_RDLOAD;
                                steps_next = place;
                                rd_next    = 1'b1;
                            end
                        end
                        dqs_pkg::REQ_FILL:
                        begin
                            if (place > count_reg)
                            begin
                                stat_next = dqs_pkg::STAT_BADPOS;
                            end
                            else if (fill_over)
                            begin
                                stat_next = dqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                state_next = S_INS;
                                steps_next = amount;
                            end
                        end
                        dqs_pkg::REQ_ERASE:
                        begin
                            if (place > place_end)
                            begin
                                stat_next = dqs_pkg::STAT_BADPOS;
                            end
                            else
                            begin
                                state_next = S_DEL;
                                pos_next   = er_start;
                                steps_next = er_end - er_start;
                            end
                        end
                        dqs_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        dqs_pkg::REQ_RESIZE:
                        begin
                            if (amount > DEPTH_C)
                            begin
                                stat_next = dqs_pkg::STAT_FULL;
                            end
                            else if (amount <= count_reg)
                            begin
                                count_next = amount;
                            end
                            else
                            begin
                                state_next = S_INS;
                                pos_next   = count_reg;
                                steps_next = amount - count_reg;
                            end
                        end
                        default:
                        begin
                            stat_next = dqs_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                if (steps_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    steps_next = steps_reg - CW'(1);
                    count_next = count_reg + CW'(1);
                end
            end
            S_DEL:
            begin
                if (steps_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    steps_next = steps_reg - CW'(1);
                    count_next = count_reg - CW'(1);
                end
            end
            S_RDLOAD:
            begin
                state_next = S_RDSHIFT;
            end
            S_RDSHIFT:
            begin
                if (steps_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    steps_next = steps_reg - CW'(1);
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (fin_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        steps_reg <= steps_next;
        value_reg <= value_next;
        stat_reg  <= stat_next;
        rd_reg    <= rd_next;
        if (fin_load)
        begin
            word_reg  <= rd_reg ? tap_head : '0;
            occ_reg   <= count_reg;
            ostat_reg <= stat_reg;
        end
    end

    assign cell_ctrl.shift_in  = (state_reg == S_INS) && !steps_zero;
    assign cell_ctrl.shift_out = (state_reg == S_DEL) && !steps_zero;
    assign cell_ctrl.load_tap  = (state_reg == S_RDLOAD);
    assign cell_ctrl.tap_shift = (state_reg == S_RDSHIFT) && !steps_zero;
    assign cell_pos            = pos_reg;
    assign cell_value          = value_reg;

    assign out_valid = ovalid_reg;
    assign read_word = word_reg;
    assign occupancy = occ_reg;
    assign status    = ostat_reg;

endmodule

// File: sv/double_ended_queue_store.sv
// Request steps: clear, resize shrink and any refused request go straight to the finish state;
// push and pop at either end take one step; fill and resize growth take one step per copy;
// erase takes one step per element removed; read loads the tap at position P, then walks it P
// cells to cell zero. One request in flight. The cell row moves one position per cycle for every step.
// Reset clears occupancy and the sequencer; cell words are not reset.
module double_ended_queue_store #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [3:0]                          req_type,
    input  logic [$clog2(DEPTH+1)-1:0]          place,
    input  logic [$clog2(DEPTH+1)-1:0]          place_end,
    input  logic [$clog2(DEPTH+1)-1:0]          amount,
    input  logic [DATA_WIDTH-1:0]               item_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [DATA_WIDTH-1:0]               read_word,
    output logic [$clog2(DEPTH+1)-1:0]          occupancy,
    output logic [1:0]                          status
);

    // Position and count width: must hold DEPTH itself.
    localparam int CW = $clog2(DEPTH + 1);

    // The row is kept in element order: cell k holds element k, so the
    // front of the queue always sits in cell zero and no head pointer is
    // needed. Inserts, removals and reads are broken into single-position steps:
    //   - insert: open a gap at a position, cells above take their left neighbor
    //   - remove: close a gap at a position, cells at and above take their right
    //   - read:   the selected cell drops its word on a tap chain that walks
    //             one cell per cycle toward cell zero, where the sequencer picks it up
    // The sequencer takes a new request while a finished result beat still
    // waits in the output register.

    dqs_pkg::cell_ctrl_t   cell_ctrl;
    logic [CW-1:0]         cell_pos;
    logic [DATA_WIDTH-1:0] cell_value;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];

    dqs_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .place      (place),
        .place_end  (place_end),
        .amount     (amount),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_word  (read_word),
        .occupancy  (occupancy),
        .status     (status),
        .tap_head   (cell_tap[0]),
        .cell_ctrl  (cell_ctrl),
        .cell_pos   (cell_pos),
        .cell_value (cell_value)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;
        logic [DATA_WIDTH-1:0] right_t;

        // Ends of the row: nothing shifts in from outside.
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_inner_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
            assign right_t = '0;
        end
        else
        begin : g_inner_r
            assign right_d = cell_data[i+1];
            assign right_t = cell_tap[i+1];
        end

        dqs_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PW         (CW),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .pos        (cell_pos),
            .value      (cell_value),
            .left_data  (left_d),
            .right_data (right_d),
            .right_tap  (right_t),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

endmodule
